FILE: hw/rtl/mfd_pkg.sv
// shared types and constants of the mesh flood engine
package mfd_pkg;

  localparam logic [1:0] KIND_RX     = 2'd0;
  localparam logic [1:0] KIND_SEND   = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] ACT_TX      = 2'd0;
  localparam logic [1:0] ACT_DELIVER = 2'd1;
  localparam logic [1:0] ACT_GIVEUP  = 2'd2;
  localparam logic [1:0] ACT_ACKED   = 2'd3;

  localparam logic [7:0] BROADCAST = 8'hFF;

  localparam int unsigned RESULT_CAP = 8;
  localparam int unsigned CAP_W      = 4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_COMMAND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HOPS  = 3'd4;

  localparam logic [7:0]  RST_NODE_ID     = 8'd1;
  localparam logic [7:0]  RST_ACK_COMMAND = 8'd3;
  localparam logic [15:0] RST_ACK_TIMEOUT = 16'd1000;
  localparam logic [3:0]  RST_RETRY_LIMIT = 4'd3;
  localparam logic [7:0]  RST_START_HOPS  = 8'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic [23:0] stamp_us;
    logic [31:0] pkt_id;
    logic [7:0]  pkt_src;
    logic [7:0]  pkt_dest;
    logic [7:0]  pkt_hops;
    logic [7:0]  pkt_cmd;
    logic [31:0] pkt_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] out_id;
    logic [7:0]  out_src;
    logic [7:0]  out_dest;
    logic [7:0]  out_hops;
    logic [7:0]  out_cmd;
    logic [31:0] out_data;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  dest;
    logic [7:0]  cmd;
    logic [31:0] data;
    logic [31:0] tstamp;
    logic [3:0]  tries;
  } pend_entry_t;

  typedef enum logic [2:0] {
    RES_ACKED,
    RES_DELIVER,
    RES_ACKTX,
    RES_FWD,
    RES_SEND,
    RES_RETRY,
    RES_GIVEUP
  } res_sel_e;

  typedef enum logic [1:0] {
    REM_ITEM,
    REM_NID,
    REM_ENTRY
  } rem_sel_e;

  typedef struct packed {
    logic     latch_item;
    logic     idx_inc;
    logic     cnt_inc;
    logic     rd_rec;
    logic     rd_pend;
    logic     rd_next;
    logic     k_load;
    logic     k_inc;
    logic     shift_wr;
    logic     append;
    logic     retry_wr;
    logic     pend_dec;
    logic     remember;
    rem_sel_e rem_sel;
    logic     push;
    res_sel_e res_sel;
    logic     flush;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       is_ack;
    logic       idx_end_pend;
    logic       idx_end_rec;
    logic       rec_hit;
    logic       pend_hit;
    logic       timed_out;
    logic       tries_ok;
    logic       can_push;
    logic       hold_v;
    logic       cap_hit;
    logic       dlv_c;
    logic       ackr_c;
    logic       fwd_c;
    logic       k_end;
  } sts_t;

endpackage

FILE: hw/rtl/mfd_ctrl.sv
// sequencing state machine of the mesh flood engine
module mfd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mfd_pkg::sts_t sts_i,
  output mfd_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISP     = 4'd1;
  localparam logic [3:0] S_ACK_RD   = 4'd2;
  localparam logic [3:0] S_ACK_CMP  = 4'd3;
  localparam logic [3:0] S_SEEN_RD  = 4'd4;
  localparam logic [3:0] S_SEEN_CMP = 4'd5;
  localparam logic [3:0] S_RX_REM   = 4'd6;
  localparam logic [3:0] S_RX_DLV   = 4'd7;
  localparam logic [3:0] S_RX_ACK   = 4'd8;
  localparam logic [3:0] S_RX_FWD   = 4'd9;
  localparam logic [3:0] S_SEND     = 4'd10;
  localparam logic [3:0] S_TC_RD    = 4'd11;
  localparam logic [3:0] S_TC_CMP   = 4'd12;
  localparam logic [3:0] S_DROP_RD  = 4'd13;
  localparam logic [3:0] S_DROP_WR  = 4'd14;
  localparam logic [3:0] S_FIN      = 4'd15;

  logic [3:0] state_q, state_d;
  logic       ret_tc_q, ret_tc_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    ret_tc_d = ret_tc_q;
    cmd_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_item = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.kind)
          mfd_pkg::KIND_RX:   state_d = sts_i.is_ack ? S_ACK_RD : S_SEEN_RD;
          mfd_pkg::KIND_SEND: state_d = S_SEND;
          mfd_pkg::KIND_TICK: state_d = S_TC_RD;
          default:            state_d = S_FIN;
        endcase
      end
      S_ACK_RD: begin
        if (sts_i.idx_end_pend) begin
          state_d = S_FIN;
        end else begin
          cmd_o.rd_pend = 1'b1;
          state_d = S_ACK_CMP;
        end
      end
      S_ACK_CMP: begin
        if (!sts_i.pend_hit) begin
          cmd_o.idx_inc = 1'b1;
          state_d = S_ACK_RD;
        end else if (sts_i.can_push) begin
          cmd_o.push    = 1'b1;
          cmd_o.res_sel = mfd_pkg::RES_ACKED;
          cmd_o.k_load  = 1'b1;
          ret_tc_d = 1'b0;
          state_d  = S_DROP_RD;
        end
      end
      S_SEEN_RD: begin
        if (sts_i.idx_end_rec) begin
          state_d = S_RX_REM;
        end else begin
          cmd_o.rd_rec = 1'b1;
          state_d = S_SEEN_CMP;
        end
      end
      S_SEEN_CMP: begin
        if (sts_i.rec_hit) begin
          state_d = S_FIN;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = S_SEEN_RD;
        end
      end
      S_RX_REM: begin
        cmd_o.remember = 1'b1;
        cmd_o.rem_sel  = mfd_pkg::REM_ITEM;
        state_d = S_RX_DLV;
      end
      S_RX_DLV: begin
        if (!sts_i.dlv_c) begin
          state_d = S_RX_ACK;
        end else if (sts_i.can_push) begin
          cmd_o.push    = 1'b1;
          cmd_o.res_sel = mfd_pkg::RES_DELIVER;
          state_d = S_RX_ACK;
        end
      end
      S_RX_ACK: begin
        if (!sts_i.ackr_c) begin
          state_d = S_RX_FWD;
        end else if (sts_i.can_push) begin
          cmd_o.push    = 1'b1;
          cmd_o.res_sel = mfd_pkg::RES_ACKTX;
          state_d = S_RX_FWD;
        end
      end
      S_RX_FWD: begin
        if (!sts_i.fwd_c) begin
          state_d = S_FIN;
        end else if (sts_i.can_push) begin
          cmd_o.push    = 1'b1;
          cmd_o.res_sel = mfd_pkg::RES_FWD;
          state_d = S_FIN;
        end
      end
      S_SEND: begin
        if (sts_i.can_push) begin
          cmd_o.push     = 1'b1;
          cmd_o.res_sel  = mfd_pkg::RES_SEND;
          cmd_o.remember = 1'b1;
          cmd_o.rem_sel  = mfd_pkg::REM_NID;
          cmd_o.append   = 1'b1;
          state_d = S_FIN;
        end
      end
      S_TC_RD: begin
        if (sts_i.idx_end_pend || sts_i.cap_hit) begin
          state_d = S_FIN;
        end else begin
          cmd_o.rd_pend = 1'b1;
          state_d = S_TC_CMP;
        end
      end
      S_TC_CMP: begin
        if (!sts_i.timed_out) begin
          cmd_o.idx_inc = 1'b1;
          state_d = S_TC_RD;
        end else if (sts_i.can_push) begin
          cmd_o.push    = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          if (sts_i.tries_ok) begin
            cmd_o.res_sel  = mfd_pkg::RES_RETRY;
            cmd_o.remember = 1'b1;
            cmd_o.rem_sel  = mfd_pkg::REM_ENTRY;
            cmd_o.retry_wr = 1'b1;
            cmd_o.idx_inc  = 1'b1;
            state_d = S_TC_RD;
          end else begin
            cmd_o.res_sel = mfd_pkg::RES_GIVEUP;
            cmd_o.k_load  = 1'b1;
            ret_tc_d = 1'b1;
            state_d  = S_DROP_RD;
          end
        end
      end
      S_DROP_RD: begin
        if (sts_i.k_end) begin
          cmd_o.pend_dec = 1'b1;
          state_d = ret_tc_q ? S_TC_RD : S_FIN;
        end else begin
          cmd_o.rd_pend = 1'b1;
          cmd_o.rd_next = 1'b1;
          state_d = S_DROP_WR;
        end
      end
      S_DROP_WR: begin
        cmd_o.shift_wr = 1'b1;
        cmd_o.k_inc    = 1'b1;
        state_d = S_DROP_RD;
      end
      S_FIN: begin
        // last result of the item leaves the hold stage with its last flag
        if (!sts_i.hold_v) begin
          state_d = S_IDLE;
        end else if (sts_i.can_push) begin
          cmd_o.flush = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_tc_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_tc_q <= ret_tc_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !sts_i.hold_v)
    else $error("hold stage still full while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DROP_WR) |-> ($past(state_q) == S_DROP_RD))
    else $error("table shift write without a read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.push || cmd_o.flush) |-> sts_i.can_push)
    else $error("result pushed while output path full");

endmodule

FILE: hw/rtl/mfd_dp.sv
// datapath: registers, recent-id ring, pending table and result staging
module mfd_dp #(
  parameter int unsigned RecentDepth  = 16,
  parameter int unsigned PendingDepth = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mfd_pkg::in_item_t                in_item_i,
  input  logic                             cfg_valid_i,
  input  logic [mfd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mfd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output mfd_pkg::out_item_t               out_item_o,
  input  mfd_pkg::cmd_t                    cmd_i,
  output mfd_pkg::sts_t                    sts_o
);

  localparam int unsigned RAW  = $clog2(RecentDepth);
  localparam int unsigned PAW  = (PendingDepth > 1) ? $clog2(PendingDepth) : 1;
  localparam int unsigned CW   = $clog2(PendingDepth + 1);
  localparam int unsigned MAXD = (RecentDepth > PendingDepth) ? RecentDepth : PendingDepth;
  localparam int unsigned IW   = $clog2(MAXD + 1);

  logic [7:0]  node_q, ackc_q, hops0_q;
  logic [15:0] tmo_q;
  logic [3:0]  limit_q;

  mfd_pkg::in_item_t item_q;

  logic [IW-1:0]    idx_q;
  logic [CW-1:0]    k_q, k_nx;
  logic [CW-1:0]    count_q;
  logic [mfd_pkg::CAP_W-1:0] cnt_q;
  logic [RAW-1:0]   wr_ptr_q;
  logic             full_q;

  logic [31:0] rec_mem [RecentDepth];
  logic [31:0] rec_rd_q;
  mfd_pkg::pend_entry_t pend_mem [PendingDepth];
  mfd_pkg::pend_entry_t pend_rd_q, pend_new, pend_upd;
  logic [PAW-1:0] pend_raddr;

  mfd_pkg::out_item_t res_new, hold_q, out_q, out_d;
  logic hold_v_q, out_v_q;

  logic [31:0] nid, rem_id, elapsed;
  logic        queue_ok, can_push;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q  <= mfd_pkg::RST_NODE_ID;
      ackc_q  <= mfd_pkg::RST_ACK_COMMAND;
      tmo_q   <= mfd_pkg::RST_ACK_TIMEOUT;
      limit_q <= mfd_pkg::RST_RETRY_LIMIT;
      hops0_q <= mfd_pkg::RST_START_HOPS;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mfd_pkg::CFG_NODE_ID:     node_q  <= cfg_data_i[7:0];
        mfd_pkg::CFG_ACK_COMMAND: ackc_q  <= cfg_data_i[7:0];
        mfd_pkg::CFG_ACK_TIMEOUT: tmo_q   <= cfg_data_i;
        mfd_pkg::CFG_RETRY_LIMIT: limit_q <= cfg_data_i[3:0];
        mfd_pkg::CFG_START_HOPS:  hops0_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) item_q <= in_item_i;
  end

  assign nid      = {node_q, item_q.stamp_us};
  assign k_nx     = k_q + 1'b1;
  assign queue_ok = (item_q.pkt_dest != mfd_pkg::BROADCAST) && (item_q.pkt_cmd != ackc_q)
                    && (count_q < CW'(PendingDepth));

  always_comb begin
    case (cmd_i.rem_sel)
      mfd_pkg::REM_NID:   rem_id = nid;
      mfd_pkg::REM_ENTRY: rem_id = pend_rd_q.id;
      default:            rem_id = item_q.pkt_id;
    endcase
  end

  // counters and ring pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      k_q      <= '0;
      count_q  <= '0;
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      full_q   <= 1'b0;
    end else begin
      if (cmd_i.latch_item) begin
        idx_q <= '0;
        cnt_q <= '0;
      end else begin
        if (cmd_i.idx_inc) idx_q <= idx_q + 1'b1;
        if (cmd_i.cnt_inc) cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.k_load) begin
        k_q <= CW'(idx_q);
      end else if (cmd_i.k_inc) begin
        k_q <= k_nx;
      end
      if (cmd_i.append && queue_ok) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.pend_dec && (count_q != '0)) begin
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.remember) begin
        if (wr_ptr_q == RAW'(RecentDepth - 1)) begin
          wr_ptr_q <= '0;
          full_q   <= 1'b1;
        end else begin
          wr_ptr_q <= wr_ptr_q + 1'b1;
        end
      end
    end
  end

  // recent-id ring
  always_ff @(posedge clk_i) begin
    if (cmd_i.remember) rec_mem[wr_ptr_q] <= rem_id;
    if (cmd_i.rd_rec) rec_rd_q <= rec_mem[idx_q[RAW-1:0]];
  end

  // pending table
  assign pend_raddr = cmd_i.rd_next ? k_nx[PAW-1:0] : idx_q[PAW-1:0];

  always_comb begin
    pend_new.id     = nid;
    pend_new.dest   = item_q.pkt_dest;
    pend_new.cmd    = item_q.pkt_cmd;
    pend_new.data   = item_q.pkt_data;
    pend_new.tstamp = item_q.now_ms;
    pend_new.tries  = 4'd0;
    pend_upd        = pend_rd_q;
    pend_upd.tstamp = item_q.now_ms;
    pend_upd.tries  = pend_rd_q.tries + 4'd1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && queue_ok) begin
      pend_mem[count_q[PAW-1:0]] <= pend_new;
    end else if (cmd_i.retry_wr) begin
      pend_mem[idx_q[PAW-1:0]] <= pend_upd;
    end else if (cmd_i.shift_wr) begin
      pend_mem[k_q[PAW-1:0]] <= pend_rd_q;
    end
    if (cmd_i.rd_pend) pend_rd_q <= pend_mem[pend_raddr];
  end

  // result builder
  always_comb begin
    res_new.last = 1'b0;
    case (cmd_i.res_sel) inside
      mfd_pkg::RES_ACKED, mfd_pkg::RES_DELIVER, mfd_pkg::RES_FWD: begin
        res_new.action   = (cmd_i.res_sel == mfd_pkg::RES_ACKED) ? mfd_pkg::ACT_ACKED :
                           (cmd_i.res_sel == mfd_pkg::RES_DELIVER) ? mfd_pkg::ACT_DELIVER :
                           mfd_pkg::ACT_TX;
        res_new.out_id   = item_q.pkt_id;
        res_new.out_src  = item_q.pkt_src;
        res_new.out_dest = item_q.pkt_dest;
        res_new.out_hops = (cmd_i.res_sel == mfd_pkg::RES_FWD) ? item_q.pkt_hops - 8'd1
                                                              : item_q.pkt_hops;
        res_new.out_cmd  = item_q.pkt_cmd;
        res_new.out_data = item_q.pkt_data;
      end
      mfd_pkg::RES_ACKTX: begin
        res_new.action   = mfd_pkg::ACT_TX;
        res_new.out_id   = item_q.pkt_id;
        res_new.out_src  = node_q;
        res_new.out_dest = item_q.pkt_src;
        res_new.out_hops = 8'd1;
        res_new.out_cmd  = ackc_q;
        res_new.out_data = 32'd0;
      end
      mfd_pkg::RES_SEND: begin
        res_new.action   = mfd_pkg::ACT_TX;
        res_new.out_id   = nid;
        res_new.out_src  = node_q;
        res_new.out_dest = item_q.pkt_dest;
        res_new.out_hops = hops0_q;
        res_new.out_cmd  = item_q.pkt_cmd;
        res_new.out_data = item_q.pkt_data;
      end
      default: begin
        res_new.action   = (cmd_i.res_sel == mfd_pkg::RES_RETRY) ? mfd_pkg::ACT_TX
                                                                : mfd_pkg::ACT_GIVEUP;
        res_new.out_id   = pend_rd_q.id;
        res_new.out_src  = node_q;
        res_new.out_dest = pend_rd_q.dest;
        res_new.out_hops = (cmd_i.res_sel == mfd_pkg::RES_RETRY) ? hops0_q : 8'd0;
        res_new.out_cmd  = pend_rd_q.cmd;
        res_new.out_data = pend_rd_q.data;
      end
    endcase
  end

  // one result is held back until the next one or the end of the item sets its last flag
  assign can_push = !hold_v_q || !out_v_q || out_ready_i;

  always_comb begin
    out_d      = hold_q;
    out_d.last = cmd_i.flush;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) hold_q <= res_new;
    if ((cmd_i.push && hold_v_q) || cmd_i.flush) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cmd_i.push) begin
        hold_v_q <= 1'b1;
      end else if (cmd_i.flush) begin
        hold_v_q <= 1'b0;
      end
      if ((cmd_i.push && hold_v_q) || cmd_i.flush) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  assign elapsed = item_q.now_ms - pend_rd_q.tstamp;

  always_comb begin
    sts_o.kind         = item_q.kind;
    sts_o.is_ack       = (item_q.pkt_cmd == ackc_q);
    sts_o.idx_end_pend = (idx_q >= IW'(count_q));
    sts_o.idx_end_rec  = full_q ? (idx_q >= IW'(RecentDepth)) : (idx_q >= IW'(wr_ptr_q));
    sts_o.rec_hit      = (rec_rd_q == item_q.pkt_id);
    sts_o.pend_hit     = (pend_rd_q.id == item_q.pkt_id);
    sts_o.timed_out    = (elapsed > {16'd0, tmo_q});
    sts_o.tries_ok     = (pend_rd_q.tries < limit_q);
    sts_o.can_push     = can_push;
    sts_o.hold_v       = hold_v_q;
    sts_o.cap_hit      = (cnt_q >= mfd_pkg::CAP_W'(mfd_pkg::RESULT_CAP));
    sts_o.dlv_c        = (item_q.pkt_dest == node_q) || (item_q.pkt_dest == mfd_pkg::BROADCAST);
    sts_o.ackr_c       = (item_q.pkt_dest == node_q);
    sts_o.fwd_c        = (item_q.pkt_hops != 8'd0) && (item_q.pkt_dest != node_q);
    sts_o.k_end        = ({1'b0, k_nx} >= {1'b0, count_q});
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(PendingDepth))
    else $error("pending count beyond table depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.append, cmd_i.retry_wr, cmd_i.shift_wr}))
    else $error("two pending table writes at once");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i && !cmd_i.flush && !(cmd_i.push && hold_v_q))
      |=> out_v_q)
    else $error("waiting result lost");

endmodule

FILE: hw/rtl/mesh_flood_dedup_ack_retry.sv
// top level of the mesh flood engine with duplicate filter and ack retry
//
//  port group  direction  handshake               payload
//  in          in         in_valid_i/in_ready_o   in_item_i (in_item_t)
//  out         out        out_valid_o/out_ready_i out_item_o (out_item_t)
//  cfg         in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one item at a time; the ring lookup reads and then compares each stored id in turn,
// and the pending table is searched the same way for an ack and for a time check
// each give-up in a time check shifts the later table entries down with a read and a write
// results leave through a hold stage and an output register; a full output stalls the scan
// reset clears pointers, counts, valid flags and configuration registers; ring and table contents are not cleared
module mesh_flood_dedup_ack_retry #(
  parameter int unsigned RecentDepth  = 16,
  parameter int unsigned PendingDepth = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  mfd_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output mfd_pkg::out_item_t              out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mfd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mfd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  mfd_pkg::cmd_t cmd;
  mfd_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  mfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mfd_dp #(
    .RecentDepth  (RecentDepth),
    .PendingDepth (PendingDepth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

FILE: tb/mesh_flood_dedup_ack_retry_tb.sv
// self-checking testbench of the mesh flood engine with duplicate filter and ack retry
`timescale 1ns / 1ps

module mesh_flood_dedup_ack_retry_tb;

  localparam int unsigned RING_N  = 16;
  localparam int unsigned TABLE_N = 8;
  localparam int unsigned DRAIN   = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  mfd_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mfd_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mfd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mfd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  always #5 clk_i = ~clk_i;

  mesh_flood_dedup_ack_retry dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // node settings as the engine should hold them
  logic [7:0]  node_id_m, ack_cmd_m, hops_m;
  logic [15:0] timeout_m;
  logic [3:0]  retry_m;

  logic [31:0] ring_ids [RING_N];
  logic [3:0]  ring_ptr;
  logic        ring_full;
  mfd_pkg::pend_entry_t table_q [TABLE_N];
  int unsigned table_cnt;

  mfd_pkg::in_item_t  send_queue [$];
  mfd_pkg::out_item_t result_queue [$];
  logic [31:0] sent_ids [$];
  logic [31:0] heard_ids [$];
  logic [31:0] now_t;

  int unsigned errors, items_in, results_seen, phases;
  int unsigned tx_gap, rx_gap;
  bit no_idle, send_hold, rx_long, long_go;

  function automatic bit id_seen(logic [31:0] id);
    int unsigned lim;
    lim = ring_full ? RING_N : 32'(ring_ptr);
    for (int unsigned i = 0; i < lim; i++) if (ring_ids[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void record_id(logic [31:0] id);
    ring_ids[ring_ptr] = id;
    ring_ptr = ring_ptr + 4'd1;
    if (ring_ptr == 4'd0) ring_full = 1'b1;
  endfunction

  function automatic void drop_pending(int unsigned idx);
    for (int unsigned k = idx; k + 1 < table_cnt; k++) table_q[k] = table_q[k + 1];
    if (table_cnt > 0) table_cnt--;
  endfunction

  function automatic mfd_pkg::out_item_t mk_result(logic [1:0] act, logic [31:0] id,
                                                   logic [7:0] src, logic [7:0] dst,
                                                   logic [7:0] hops, logic [7:0] cmd,
                                                   logic [31:0] data);
    mfd_pkg::out_item_t r;
    r = '{action: act, out_id: id, out_src: src, out_dest: dst, out_hops: hops,
          out_cmd: cmd, out_data: data, last: 1'b0};
    return r;
  endfunction

  // works out the packets an accepted item should produce and updates node state
  function automatic void predict_packets(mfd_pkg::in_item_t it);
    mfd_pkg::out_item_t r [$];
    logic [31:0] nid, elapsed;
    int unsigned i;
    case (it.kind)
      mfd_pkg::KIND_RX: begin
        if (it.pkt_cmd == ack_cmd_m) begin
          for (i = 0; i < table_cnt; i++) begin
            if (table_q[i].id == it.pkt_id) begin
              drop_pending(i);
              r.push_back(mk_result(mfd_pkg::ACT_ACKED, it.pkt_id, it.pkt_src, it.pkt_dest,
                                    it.pkt_hops, it.pkt_cmd, it.pkt_data));
              break;
            end
          end
        end else if (!id_seen(it.pkt_id)) begin
          record_id(it.pkt_id);
          if (it.pkt_dest == node_id_m || it.pkt_dest == mfd_pkg::BROADCAST) begin
            r.push_back(mk_result(mfd_pkg::ACT_DELIVER, it.pkt_id, it.pkt_src, it.pkt_dest,
                                  it.pkt_hops, it.pkt_cmd, it.pkt_data));
            if (it.pkt_dest == node_id_m)
              r.push_back(mk_result(mfd_pkg::ACT_TX, it.pkt_id, node_id_m, it.pkt_src, 8'd1,
                                    ack_cmd_m, 32'd0));
          end
          if (it.pkt_hops != 8'd0 && it.pkt_dest != node_id_m)
            r.push_back(mk_result(mfd_pkg::ACT_TX, it.pkt_id, it.pkt_src, it.pkt_dest,
                                  it.pkt_hops - 8'd1, it.pkt_cmd, it.pkt_data));
        end
      end
      mfd_pkg::KIND_SEND: begin
        nid = {node_id_m, it.stamp_us};
        r.push_back(mk_result(mfd_pkg::ACT_TX, nid, node_id_m, it.pkt_dest, hops_m,
                              it.pkt_cmd, it.pkt_data));
        record_id(nid);
        if (it.pkt_dest != mfd_pkg::BROADCAST && it.pkt_cmd != ack_cmd_m &&
            table_cnt < TABLE_N) begin
          table_q[table_cnt] = '{id: nid, dest: it.pkt_dest, cmd: it.pkt_cmd,
                                 data: it.pkt_data, tstamp: it.now_ms, tries: 4'd0};
          table_cnt++;
        end
      end
      mfd_pkg::KIND_TICK: begin
        i = 0;
        while (i < table_cnt && r.size() < mfd_pkg::RESULT_CAP) begin
          elapsed = it.now_ms - table_q[i].tstamp;
          if (elapsed > {16'd0, timeout_m}) begin
            if (table_q[i].tries < retry_m) begin
              r.push_back(mk_result(mfd_pkg::ACT_TX, table_q[i].id, node_id_m,
                                    table_q[i].dest, hops_m, table_q[i].cmd,
                                    table_q[i].data));
              record_id(table_q[i].id);
              table_q[i].tstamp = it.now_ms;
              table_q[i].tries = table_q[i].tries + 4'd1;
              i++;
            end else begin
              r.push_back(mk_result(mfd_pkg::ACT_GIVEUP, table_q[i].id, node_id_m,
                                    table_q[i].dest, 8'd0, table_q[i].cmd,
                                    table_q[i].data));
              drop_pending(i);
            end
          end else begin
            i++;
          end
        end
      end
      default: ;
    endcase
    if (r.size() > 0) r[r.size() - 1].last = 1'b1;
    foreach (r[j]) result_queue.push_back(r[j]);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (no_idle || p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sender
  always @(posedge clk_i) begin
    bit v;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      v = in_valid;
      if (in_valid && in_ready) begin
        predict_packets(in_item);
        items_in++;
        v = 1'b0;
      end
      if (!v) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (!send_hold && send_queue.size() > 0) begin
          in_item <= send_queue.pop_front();
          v = 1'b1;
          tx_gap = pick_gap();
        end
      end
      in_valid <= v;
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // receiver and result checker
  always @(posedge clk_i) begin
    mfd_pkg::out_item_t e;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (result_queue.size() == 0) begin
          $error("unexpected packet: action %0d id %0h", out_item.action, out_item.out_id);
          errors++;
        end else begin
          e = result_queue.pop_front();
          check_field("action", 32'(e.action), 32'(out_item.action));
          check_field("out_id", e.out_id, out_item.out_id);
          check_field("out_src", 32'(e.out_src), 32'(out_item.out_src));
          check_field("out_dest", 32'(e.out_dest), 32'(out_item.out_dest));
          check_field("out_hops", 32'(e.out_hops), 32'(out_item.out_hops));
          check_field("out_cmd", 32'(e.out_cmd), 32'(out_item.out_cmd));
          check_field("out_data", e.out_data, out_item.out_data);
          check_field("last", 32'(e.last), 32'(out_item.last));
        end
      end
      if (rx_long) begin
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rx_gap = pick_gap();
      end
    end
  end

  // long receiver hold-off, counted here
  initial begin
    wait (long_go);
    rx_long = 1'b1;
    repeat (500) @(posedge clk_i);
    rx_long = 1'b0;
  end

  task automatic cfg_write(logic [mfd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      mfd_pkg::CFG_NODE_ID:     node_id_m = val[7:0];
      mfd_pkg::CFG_ACK_COMMAND: ack_cmd_m = val[7:0];
      mfd_pkg::CFG_ACK_TIMEOUT: timeout_m = val;
      mfd_pkg::CFG_RETRY_LIMIT: retry_m = val[3:0];
      mfd_pkg::CFG_START_HOPS:  hops_m = val[7:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (send_queue.size() != 0 || in_valid || result_queue.size() != 0);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic add_item(logic [1:0] kind, logic [23:0] stamp, logic [31:0] id,
                          logic [7:0] src, logic [7:0] dst, logic [7:0] hops,
                          logic [7:0] cmd, logic [31:0] data);
    send_queue.push_back('{kind: kind, now_ms: now_t, stamp_us: stamp, pkt_id: id,
                           pkt_src: src, pkt_dest: dst, pkt_hops: hops, pkt_cmd: cmd,
                           pkt_data: data});
    if (kind == mfd_pkg::KIND_SEND) sent_ids.push_back({node_id_m, stamp});
    if (kind == mfd_pkg::KIND_RX) heard_ids.push_back(id);
  endtask

  task automatic add_random(int unsigned n);
    int unsigned p;
    logic [7:0] dst, cmd, hops;
    logic [31:0] id;
    for (int unsigned k = 0; k < n; k++) begin
      p = $urandom_range(0, 99);
      now_t = now_t + $urandom_range(0, 60);
      cmd = 8'($urandom());
      if (cmd == ack_cmd_m) cmd = cmd + 8'd1;
      case ($urandom_range(0, 9))
        0, 1:    dst = mfd_pkg::BROADCAST;
        2, 3, 4: dst = node_id_m;
        default: dst = 8'($urandom());
      endcase
      hops = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 2));
      if (p < 28) begin
        if ($urandom_range(0, 9) == 0) cmd = ack_cmd_m;
        if (dst == node_id_m) dst = 8'($urandom());
        add_item(mfd_pkg::KIND_SEND, 24'($urandom()), $urandom(), 8'($urandom()), dst, hops,
                 cmd, $urandom());
      end else if (p < 48 || heard_ids.size() == 0) begin
        add_item(mfd_pkg::KIND_RX, 24'($urandom()), $urandom(), 8'($urandom()), dst, hops,
                 cmd, $urandom());
      end else if (p < 58) begin
        id = ($urandom_range(0, 1) && sent_ids.size() > 0) ?
             sent_ids[$urandom_range(0, sent_ids.size() - 1)] :
             heard_ids[$urandom_range(0, heard_ids.size() - 1)];
        add_item(mfd_pkg::KIND_RX, 24'($urandom()), id, 8'($urandom()), dst, hops, cmd,
                 $urandom());
      end else if (p < 72) begin
        id = ($urandom_range(0, 4) != 0 && sent_ids.size() > 0) ?
             sent_ids[$urandom_range(0, sent_ids.size() - 1)] : $urandom();
        add_item(mfd_pkg::KIND_RX, 24'($urandom()), id, 8'($urandom()), 8'($urandom()),
                 8'($urandom()), ack_cmd_m, $urandom());
      end else if (p < 95) begin
        if ($urandom_range(0, 1)) now_t = now_t + 32'(timeout_m) + $urandom_range(1, 20);
        add_item(mfd_pkg::KIND_TICK, 24'($urandom()), $urandom(), 8'($urandom()),
                 8'($urandom()), 8'($urandom()), 8'($urandom()), $urandom());
      end else begin
        add_item(mfd_pkg::KIND_UNUSED, 24'($urandom()), $urandom(), 8'($urandom()),
                 8'($urandom()), 8'($urandom()), 8'($urandom()), $urandom());
      end
    end
  endtask

  task automatic set_node(logic [7:0] nid, logic [7:0] ackc, logic [15:0] tmo,
                          logic [3:0] retry, logic [7:0] hops);
    cfg_write(mfd_pkg::CFG_NODE_ID, {8'd0, nid});
    cfg_write(mfd_pkg::CFG_ACK_COMMAND, {8'd0, ackc});
    cfg_write(mfd_pkg::CFG_ACK_TIMEOUT, tmo);
    cfg_write(mfd_pkg::CFG_RETRY_LIMIT, {12'd0, retry});
    cfg_write(mfd_pkg::CFG_START_HOPS, {8'd0, hops});
    sent_ids.delete();
    phases++;
  endtask

  initial begin
    node_id_m = mfd_pkg::RST_NODE_ID;
    ack_cmd_m = mfd_pkg::RST_ACK_COMMAND;
    timeout_m = mfd_pkg::RST_ACK_TIMEOUT;
    retry_m = mfd_pkg::RST_RETRY_LIMIT;
    hops_m = mfd_pkg::RST_START_HOPS;
    ring_ptr = '0;
    ring_full = 1'b0;
    table_cnt = 0;
    now_t = 32'hFFFF_F000;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings, time close to the wrap point
    add_item(mfd_pkg::KIND_SEND, 24'h0, 32'h0, 8'h0, 8'h05, 8'h0, 8'h07, 32'h0);
    add_item(mfd_pkg::KIND_SEND, 24'hFFFFFF, 32'h0, 8'h0, mfd_pkg::BROADCAST, 8'h0, 8'hFF,
             32'hFFFF_FFFF);
    add_item(mfd_pkg::KIND_SEND, 24'h12, 32'h0, 8'h0, 8'h09, 8'h0, mfd_pkg::RST_ACK_COMMAND,
             32'h5);
    add_item(mfd_pkg::KIND_RX, 24'h0, 32'hA000_0001, 8'h07, mfd_pkg::RST_NODE_ID, 8'h0, 8'h00,
             32'h1234);
    add_item(mfd_pkg::KIND_RX, 24'h0, 32'hB000_0002, 8'h08, mfd_pkg::BROADCAST, 8'h2, 8'h10,
             32'h4321);
    add_item(mfd_pkg::KIND_RX, 24'h0, 32'hC000_0003, 8'h09, 8'h40, 8'h0, 8'h11, 32'h0);
    add_item(mfd_pkg::KIND_RX, 24'h0, 32'hFFFF_FFFF, 8'hFF, 8'h80, 8'hFF, 8'hFE,
             32'hFFFF_FFFF);
    add_item(mfd_pkg::KIND_RX, 24'h0, 32'hA000_0001, 8'h07, mfd_pkg::RST_NODE_ID, 8'h3, 8'h00,
             32'h1234);
    add_item(mfd_pkg::KIND_RX, 24'h0, 32'h0100_0000, 8'h05, mfd_pkg::RST_NODE_ID, 8'h1,
             mfd_pkg::RST_ACK_COMMAND, 32'h0);
    add_item(mfd_pkg::KIND_RX, 24'h0, 32'h0DEA_D000, 8'h05, mfd_pkg::RST_NODE_ID, 8'h1,
             mfd_pkg::RST_ACK_COMMAND, 32'h0);
    add_item(mfd_pkg::KIND_UNUSED, 24'hFFFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
             32'hFFFF_FFFF);
    add_item(mfd_pkg::KIND_TICK, 24'h0, 32'h0, 8'h0, 8'h0, 8'h0, 8'h0, 32'h0);
    // nine sends: the table fills and the last one is not tracked
    for (int unsigned s = 1; s <= 9; s++)
      add_item(mfd_pkg::KIND_SEND, 24'(s), 32'h0, 8'h0, 8'(s), 8'h0, 8'h20, 32'(s * 3));
    // retries until the limit, then give-ups, across the time wrap
    for (int unsigned t = 0; t < 5; t++) begin
      now_t = now_t + 32'd1001;
      add_item(mfd_pkg::KIND_TICK, 24'h0, 32'h0, 8'h0, 8'h0, 8'h0, 8'h0, 32'h0);
    end
    wait_idle();

    set_node(8'd0, 8'd0, 16'd1, 4'd0, 8'd0);
    add_random(25);
    wait_idle();

    // long receiver stall with the input backed up
    set_node(8'd254, 8'd255, 16'hFFFF, 4'd15, 8'd255);
    no_idle = 1'b1;
    add_random(10);
    long_go = 1'b1;
    add_random(12);
    wait_idle();
    no_idle = 1'b0;

    // sender pause until every expected result has come
    add_random(3);
    do @(posedge clk_i); while (send_queue.size() != 0);
    send_hold = 1'b1;
    add_random(5);
    do @(posedge clk_i); while (in_valid || result_queue.size() != 0);
    send_hold = 1'b0;
    wait_idle();

    set_node(8'($urandom_range(0, 254)), 8'($urandom()), 16'($urandom_range(1, 200)),
             4'($urandom_range(0, 15)), 8'($urandom()));
    add_random(17);
    wait_idle();

    set_node(8'($urandom_range(0, 254)), 8'($urandom()), 16'($urandom_range(1, 65535)),
             4'($urandom_range(0, 15)), 8'($urandom()));
    add_random(17);
    wait_idle();

    $display("covered %0d items and %0d packets over %0d node settings",
             items_in, results_seen, phases + 1);
    if (errors == 0) $display("mesh_flood_dedup_ack_retry regression: pass");
    else $display("mesh_flood_dedup_ack_retry regression: fail");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("mesh_flood_dedup_ack_retry regression: fail");
    $finish;
  end

endmodule
